FILE: rtl/rsi_thr_pkg.sv
// rsi_thr_pkg: shared types and constants for the RSI threshold signal block.
// Used by rsi_threshold_signal_top; no dependencies.

package rsi_thr_pkg;

    // Default build parameters
    localparam int DEF_MAX_WINDOW = 64;
    localparam int DEF_PRICE_BITS = 32;

    // Field widths fixed by the interface
    localparam int IDX_W    = 15;
    localparam int QUOT_W   = 4;     // counter over IDX_W quotient bits
    localparam int WLEN_W   = 7;
    localparam int QTY_W    = 24;
    localparam int TIME_W   = 63;
    localparam int ID_W     = 32;
    localparam int PRICE_W  = 32;

    // Index scale: 25600 = (1 << 14) + (1 << 13) + (1 << 10)
    localparam logic [IDX_W-1:0] INDEX_FULL = 15'd25600;

    // Register map (word index in paddr[3:2])
    localparam logic [1:0] REG_WINDOW_LENGTH    = 2'd0;
    localparam logic [1:0] REG_OVERSOLD_LEVEL   = 2'd1;
    localparam logic [1:0] REG_OVERBOUGHT_LEVEL = 2'd2;
    localparam logic [1:0] REG_ORDER_QUANTITY   = 2'd3;

    // Register reset values
    localparam logic [WLEN_W-1:0] RST_WINDOW_LENGTH    = 7'd14;
    localparam logic [IDX_W-1:0]  RST_OVERSOLD_LEVEL   = 15'd7680;
    localparam logic [IDX_W-1:0]  RST_OVERBOUGHT_LEVEL = 15'd17920;
    localparam logic [QTY_W-1:0]  RST_ORDER_QUANTITY   = 24'd100;

    // Order action codes
    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_BUY  = 2'd1;
    localparam logic [1:0] ACT_SELL = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_DROP,
        S_PUSH,
        S_CHECK,
        S_DIV,
        S_DECIDE,
        S_OUT
    } t_state;

endpackage

FILE: rtl/rsi_thr_ram.sv
// rsi_thr_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.

module rsi_thr_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/rsi_threshold_signal_top.sv
// rsi_threshold_signal_top: RSI (Cutler, windowed sums) threshold trading signal.
// Depends on rsi_thr_pkg and rsi_thr_ram.
//
// Usage:
//   s_axis carries one price bar per transaction: tdata = {bar_time, close_price}.
//   m_axis returns exactly one result per bar: tuser = {action, index_ready},
//   tdata = {order_size, order_time, order_price, order_id, index_value}.
//   An APB port sets window length, oversold/overbought levels and the order
//   quantity; write it only while no bar is in flight.
//
// Operation: a bar is taken in the idle state, then a small sequencer walks it
//   through the window RAM (read oldest, drop, push) and one shared add/sub unit
//   that also runs a restoring divider for floor(25600*G/(G+L)), one quotient
//   bit per cycle. The first bar only records its close and goes to the output;
//   a later bar first reads and drops the oldest change when the window is full,
//   then pushes its own change and, once the window is full, decides, after the
//   divider's iterations unless the loss sum is zero. The result is loaded in
//   the output state; s_axis_tready is high only in the idle state.
//   The result sits in an output register, so the next bar is accepted while
//   it waits; a stalled receiver holds the sequencer only at the hand-off.
// Reset (synchronous, active low) restores register defaults, empties the
//   window (fill count zero, so no RAM sweep is needed) and sets the order id
//   to one.

module rsi_threshold_signal_top
    import rsi_thr_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW,
    parameter int PRICE_BITS = DEF_PRICE_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // APB configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // Bar input: [31:0] close_price, [94:32] bar_time, [95] zero
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,
    // Result: [14:0] index_value, [46:15] order_id, [78:47] order_price,
    //         [141:79] order_time, [165:142] order_size, [167:166] zero
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [167:0] m_axis_tdata,
    // Result kind: [0] index_ready, [2:1] action
    output logic [2:0]   m_axis_tuser
);

    // Price bits actually used; the port is 32 bits wide
    localparam int PW     = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;
    localparam int CHG_W  = PW + 1;                       // signed change
    localparam int AW     = $clog2(MAX_WINDOW);           // window address
    localparam int FILL_W = $clog2(MAX_WINDOW + 1);       // fill count
    localparam int CW     = (FILL_W > WLEN_W) ? FILL_W : WLEN_W;
    localparam int SUM_W  = PW + $clog2(MAX_WINDOW);      // gain/loss sums
    localparam int DW     = SUM_W + IDX_W;                // 25600 * G

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [WLEN_W-1:0] r_window_length;
    logic [IDX_W-1:0]  r_oversold_level;
    logic [IDX_W-1:0]  r_overbought_level;
    logic [QTY_W-1:0]  r_order_quantity;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length    <= RST_WINDOW_LENGTH;
            r_oversold_level   <= RST_OVERSOLD_LEVEL;
            r_overbought_level <= RST_OVERBOUGHT_LEVEL;
            r_order_quantity   <= RST_ORDER_QUANTITY;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_WINDOW_LENGTH:    r_window_length    <= pwdata[WLEN_W-1:0];
                REG_OVERSOLD_LEVEL:   r_oversold_level   <= pwdata[IDX_W-1:0];
                REG_OVERBOUGHT_LEVEL: r_overbought_level <= pwdata[IDX_W-1:0];
                REG_ORDER_QUANTITY:   r_order_quantity   <= pwdata[QTY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_WINDOW_LENGTH:    prdata = 32'(r_window_length);
            REG_OVERSOLD_LEVEL:   prdata = 32'(r_oversold_level);
            REG_OVERBOUGHT_LEVEL: prdata = 32'(r_overbought_level);
            REG_ORDER_QUANTITY:   prdata = 32'(r_order_quantity);
            default:              prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Block state
    // ------------------------------------------------------------------
    t_state             r_state;
    t_state             n_state;

    logic [PW-1:0]      r_last_close;
    logic               r_have_last;
    logic [AW-1:0]      r_head;
    logic [FILL_W-1:0]  r_fill;
    logic [SUM_W-1:0]   r_gain;
    logic [SUM_W-1:0]   r_loss;
    logic               r_holding;
    logic [ID_W-1:0]    r_next_id;

    // Current bar
    logic [PW-1:0]      r_price;
    logic [TIME_W-1:0]  r_time;
    logic [CHG_W-1:0]   r_chg;

    // Divider
    logic [SUM_W-1:0]   r_rem;
    logic [SUM_W-1:0]   r_div;
    logic [IDX_W-1:0]   r_low;
    logic [IDX_W-1:0]   r_quot;
    logic [QUOT_W-1:0]  r_cnt;

    // Pending result
    logic               r_rdy;
    logic [1:0]         r_act;
    logic [ID_W-1:0]    r_ord_id;

    // Output register
    logic               r_o_valid;
    logic               r_o_index_ready;
    logic [IDX_W-1:0]   r_o_index;
    logic [1:0]         r_o_action;
    logic [ID_W-1:0]    r_o_id;
    logic [PRICE_W-1:0] r_o_price;
    logic [TIME_W-1:0]  r_o_time;
    logic [QTY_W-1:0]   r_o_size;

    // ------------------------------------------------------------------
    // Window bookkeeping
    // ------------------------------------------------------------------
    logic [CW-1:0]      wl_ext;
    logic [CW-1:0]      eff_len;
    logic               need_drop;
    logic               window_short;
    logic [FILL_W:0]    head_ext;
    logic [FILL_W:0]    pos_full;
    logic [AW-1:0]      old_pos;
    logic [AW-1:0]      head_inc;

    // Length 0 acts as 1, above the store depth acts as the depth
    always_comb begin
        wl_ext = CW'(r_window_length);
        if (wl_ext == '0) begin
            eff_len = CW'(1);
        end else if (wl_ext > CW'(MAX_WINDOW)) begin
            eff_len = CW'(MAX_WINDOW);
        end else begin
            eff_len = wl_ext;
        end
    end

    assign need_drop    = CW'(r_fill) >= eff_len;
    assign window_short = CW'(r_fill) < eff_len;

    // Oldest entry: (head - fill) mod MAX_WINDOW
    always_comb begin
        head_ext = (FILL_W + 1)'(r_head);
        if (head_ext >= (FILL_W + 1)'(r_fill)) begin
            pos_full = head_ext - (FILL_W + 1)'(r_fill);
        end else begin
            pos_full = head_ext + (FILL_W + 1)'(MAX_WINDOW) - (FILL_W + 1)'(r_fill);
        end
    end

    assign old_pos  = pos_full[AW-1:0];
    assign head_inc = (r_head == AW'(MAX_WINDOW - 1)) ? '0 : r_head + 1'b1;

    // ------------------------------------------------------------------
    // Window RAM
    // ------------------------------------------------------------------
    logic               ram_we;
    logic               ram_re;
    logic [CHG_W-1:0]   ram_rdata;

    rsi_thr_ram #(
        .WIDTH (CHG_W),
        .DEPTH (MAX_WINDOW)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_head),
        .i_wdata (r_chg),
        .i_re    (ram_re),
        .i_raddr (old_pos),
        .o_rdata (ram_rdata)
    );

    // Change magnitudes (a change never reaches -2^PW)
    logic [CHG_W-1:0]   old_neg;
    logic [PW-1:0]      old_mag;
    logic               old_gain;
    logic [CHG_W-1:0]   new_neg;
    logic [PW-1:0]      new_mag;
    logic               new_gain;

    assign old_neg  = '0 - ram_rdata;
    assign old_mag  = ram_rdata[CHG_W-1] ? old_neg[PW-1:0] : ram_rdata[PW-1:0];
    assign old_gain = !ram_rdata[CHG_W-1] && (ram_rdata != '0);
    assign new_neg  = '0 - r_chg;
    assign new_mag  = r_chg[CHG_W-1] ? new_neg[PW-1:0] : r_chg[PW-1:0];
    assign new_gain = !r_chg[CHG_W-1] && (r_chg != '0);

    // ------------------------------------------------------------------
    // Shared add/subtract unit: window sums, G+L and divider steps
    // ------------------------------------------------------------------
    logic [SUM_W:0]     au_a;
    logic [SUM_W:0]     au_b;
    logic               au_sub;
    logic [SUM_W+1:0]   au_y;
    logic               au_borrow;

    assign au_y      = au_sub ? ({1'b0, au_a} - {1'b0, au_b})
                              : ({1'b0, au_a} + {1'b0, au_b});
    assign au_borrow = au_y[SUM_W+1];

    // Scaled dividend 25600 * G by shifts and adds
    logic [DW-1:0]      gain_ext;
    logic [DW-1:0]      dividend;

    assign gain_ext = DW'(r_gain);
    assign dividend = (gain_ext << 14) + (gain_ext << 13) + (gain_ext << 10);

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    logic out_free;
    assign out_free = !r_o_valid || m_axis_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    if (!r_have_last) begin
                        n_state = S_OUT;
                    end else if (need_drop) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_PUSH;
                    end
                end
            end
            S_READ:  n_state = S_DROP;
            S_DROP:  n_state = S_PUSH;
            S_PUSH:  n_state = S_CHECK;
            S_CHECK: begin
                if (window_short) begin
                    n_state = S_OUT;
                end else if (r_loss == '0) begin
                    n_state = S_DECIDE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == QUOT_W'(IDX_W - 1)) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs to RAM and arithmetic unit
    // ------------------------------------------------------------------
    always_comb begin
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        au_a          = '0;
        au_b          = '0;
        au_sub        = 1'b0;
        case (r_state)
            S_IDLE: s_axis_tready = 1'b1;
            S_READ: ram_re = 1'b1;
            S_DROP: begin
                au_a   = {1'b0, old_gain ? r_gain : r_loss};
                au_b   = (SUM_W + 1)'(old_mag);
                au_sub = 1'b1;
            end
            S_PUSH: begin
                ram_we = 1'b1;
                au_a   = {1'b0, new_gain ? r_gain : r_loss};
                au_b   = (SUM_W + 1)'(new_mag);
            end
            S_CHECK: begin
                au_a = {1'b0, r_gain};
                au_b = {1'b0, r_loss};
            end
            S_DIV: begin
                au_a   = {r_rem, r_low[IDX_W-1]};
                au_b   = {1'b0, r_div};
                au_sub = 1'b1;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_last_close <= '0;
            r_have_last  <= 1'b0;
            r_head       <= '0;
            r_fill       <= '0;
            r_gain       <= '0;
            r_loss       <= '0;
            r_holding    <= 1'b0;
            r_next_id    <= ID_W'(1);
            r_cnt        <= '0;
            r_rdy        <= 1'b0;
            r_act        <= ACT_NONE;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_price <= s_axis_tdata[PW-1:0];
                        r_time  <= s_axis_tdata[PRICE_W +: TIME_W];
                        r_chg   <= {1'b0, s_axis_tdata[PW-1:0]} - {1'b0, r_last_close};
                        r_rdy   <= 1'b0;
                        r_act   <= ACT_NONE;
                        if (!r_have_last) begin
                            // first bar only records the close
                            r_last_close <= s_axis_tdata[PW-1:0];
                            r_have_last  <= 1'b1;
                        end
                    end
                end
                S_DROP: begin
                    if (old_gain) begin
                        r_gain <= au_y[SUM_W-1:0];
                    end else begin
                        r_loss <= au_y[SUM_W-1:0];
                    end
                    r_fill <= r_fill - 1'b1;
                end
                S_PUSH: begin
                    if (new_gain) begin
                        r_gain <= au_y[SUM_W-1:0];
                    end else begin
                        r_loss <= au_y[SUM_W-1:0];
                    end
                    r_head       <= head_inc;
                    r_fill       <= r_fill + 1'b1;
                    r_last_close <= r_price;
                end
                S_CHECK: begin
                    r_div  <= au_y[SUM_W-1:0];
                    r_rem  <= dividend[DW-1:IDX_W];
                    r_low  <= dividend[IDX_W-1:0];
                    r_cnt  <= '0;
                    r_quot <= INDEX_FULL;
                end
                S_DIV: begin
                    if (!au_borrow) begin
                        r_rem  <= au_y[SUM_W-1:0];
                        r_quot <= {r_quot[IDX_W-2:0], 1'b1};
                    end else begin
                        r_rem  <= au_a[SUM_W-1:0];
                        r_quot <= {r_quot[IDX_W-2:0], 1'b0};
                    end
                    r_low <= {r_low[IDX_W-2:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                end
                S_DECIDE: begin
                    r_rdy <= 1'b1;
                    if ((r_quot < r_oversold_level) && !r_holding) begin
                        r_act     <= ACT_BUY;
                        r_holding <= 1'b1;
                        r_ord_id  <= r_next_id;
                        r_next_id <= r_next_id + 1'b1;
                    end else if ((r_quot > r_overbought_level) && r_holding) begin
                        r_act     <= ACT_SELL;
                        r_holding <= 1'b0;
                        r_ord_id  <= r_next_id;
                        r_next_id <= r_next_id + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic out_load;
    assign out_load = (r_state == S_OUT) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_index_ready <= r_rdy;
            r_o_index       <= r_rdy ? r_quot : '0;
            r_o_action      <= r_act;
            if (r_act != ACT_NONE) begin
                r_o_id    <= r_ord_id;
                r_o_price <= PRICE_W'(r_price);
                r_o_time  <= r_time;
                r_o_size  <= r_order_quantity;
            end else begin
                r_o_id    <= '0;
                r_o_price <= '0;
                r_o_time  <= '0;
                r_o_size  <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {2'b00, r_o_size, r_o_time, r_o_price, r_o_id, r_o_index};
    assign m_axis_tuser  = {r_o_action, r_o_index_ready};

endmodule
